// File: hw/rtl/phlt_pkg.sv
// Shared constants, codes and control structs of the per-address hit limit table.
package phlt_pkg;

    localparam int TABLE_ENTRIES = 256;
    localparam int ADDRESS_BITS  = 48;
    localparam int COUNT_W       = 32;
    localparam int STATUS_W      = 2;
    localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int USED_W        = $clog2(TABLE_ENTRIES + 1);

    localparam logic [COUNT_W-1:0] LIMIT_RESET = COUNT_W'(1000);
    localparam logic [COUNT_W-1:0] COUNT_MAX   = {COUNT_W{1'b1}};

    localparam logic [STATUS_W-1:0] STATUS_WITHIN = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_OVER   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_CNT_RD,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic start;
        logic scan;
        logic take_hit;
        logic take_miss;
        logic cnt_rd;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic hit;
        logic miss;
        logic out_free;
    } t_sts;

endpackage

// File: hw/rtl/per_address_hit_limit_table.sv
// Top level of the per-address hit limit table: controller plus datapath.
//
// Keeps a saturating 32-bit hit counter per address in a table of TABLE_ENTRIES
// entries, filled in order and cleared only by reset (the fill count is reset,
// so there is no clearing pass). The one key comparator walks the key memory
// one entry per cycle, so the time from acceptance to result valid grows with
// the number of entries claimed so far and with the position of a hit. A new
// request is taken once the previous one has left for the output register;
// the result waits there until taken. hit_limit may be written at any idle time.
module per_address_hit_limit_table (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [phlt_pkg::COUNT_W-1:0]      i_cfg_wdata,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [phlt_pkg::ADDRESS_BITS-1:0] i_address,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [phlt_pkg::COUNT_W-1:0]      o_hit_count,
    output logic [phlt_pkg::STATUS_W-1:0]     o_status
);

    phlt_pkg::t_cmd cmd;
    phlt_pkg::t_sts sts;

    phlt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    phlt_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_address   (i_address),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_hit_count (o_hit_count),
        .o_status    (o_status),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

`ifndef SYNTHESIS
    a_full_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == phlt_pkg::STATUS_FULL) |-> o_hit_count == '0)
        else $error("table full result with nonzero count");
    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != phlt_pkg::STATUS_FULL) |-> o_hit_count != '0)
        else $error("stored entry reported with zero count");
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second request taken while one is in flight");
    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.start, cmd.take_hit, cmd.take_miss, cmd.cnt_rd, cmd.finish}))
        else $error("conflicting controller commands");
`endif

endmodule

// File: hw/rtl/phlt_ctrl.sv
// Controller state machine: sequences scan, claim, count update and result load.
module phlt_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  phlt_pkg::t_sts i_sts,
    output phlt_pkg::t_cmd o_cmd
);

    phlt_pkg::t_state r_state;
    phlt_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= phlt_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            phlt_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = phlt_pkg::ST_SCAN;
                end
            end
            phlt_pkg::ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.hit) begin
                    o_cmd.take_hit = 1'b1;
                    n_state        = phlt_pkg::ST_CNT_RD;
                end else if (i_sts.miss) begin
                    o_cmd.take_miss = 1'b1;
                    n_state         = phlt_pkg::ST_CNT_RD;
                end
            end
            phlt_pkg::ST_CNT_RD: begin
                o_cmd.cnt_rd = 1'b1;
                n_state      = phlt_pkg::ST_FINISH;
            end
            phlt_pkg::ST_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = phlt_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = phlt_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: hw/rtl/phlt_dp.sv
// Datapath: key and count memories, scan comparator, fill count, limit and result register.
module phlt_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [phlt_pkg::COUNT_W-1:0]      i_cfg_wdata,
    input  logic [phlt_pkg::ADDRESS_BITS-1:0] i_address,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic [phlt_pkg::COUNT_W-1:0]      o_hit_count,
    output logic [phlt_pkg::STATUS_W-1:0]     o_status,
    input  phlt_pkg::t_cmd                    i_cmd,
    output phlt_pkg::t_sts                    o_sts
);

    logic [phlt_pkg::ADDRESS_BITS-1:0] key_mem [phlt_pkg::TABLE_ENTRIES];
    logic [phlt_pkg::COUNT_W-1:0]      cnt_mem [phlt_pkg::TABLE_ENTRIES];

    logic [phlt_pkg::USED_W-1:0]       r_used;
    logic [phlt_pkg::USED_W-1:0]       r_rd_idx;
    logic                              r_rd_vld;
    logic [phlt_pkg::COUNT_W-1:0]      r_limit;
    logic                              r_out_valid;

    logic [phlt_pkg::ADDRESS_BITS-1:0] r_addr;
    logic [phlt_pkg::ADDRESS_BITS-1:0] r_key_q;
    logic [phlt_pkg::IDX_W-1:0]        r_cmp_idx;
    logic [phlt_pkg::IDX_W-1:0]        r_slot;
    logic                              r_new;
    logic                              r_full;
    logic [phlt_pkg::COUNT_W-1:0]      r_cnt_q;
    logic [phlt_pkg::COUNT_W-1:0]      r_out_count;
    logic [phlt_pkg::STATUS_W-1:0]     r_out_status;

    logic                              rd_more;
    logic                              tbl_full;
    logic [phlt_pkg::COUNT_W-1:0]      cnt_base;
    logic [phlt_pkg::COUNT_W-1:0]      cnt_inc;

    assign rd_more  = (r_rd_idx < r_used);
    assign tbl_full = (r_used == phlt_pkg::USED_W'(phlt_pkg::TABLE_ENTRIES));
    assign cnt_base = r_new ? '0 : r_cnt_q;
    assign cnt_inc  = (cnt_base == phlt_pkg::COUNT_MAX) ? cnt_base : cnt_base + 1'b1;

    assign o_sts.hit      = r_rd_vld && (r_key_q == r_addr);
    assign o_sts.miss     = !r_rd_vld && (r_rd_idx == r_used);
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    // control state; the fill count stands in for per-entry valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used      <= '0;
            r_rd_idx    <= '0;
            r_rd_vld    <= 1'b0;
            r_limit     <= phlt_pkg::LIMIT_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            if (i_cmd.start) begin
                r_rd_idx <= '0;
                r_rd_vld <= 1'b0;
            end else if (i_cmd.scan) begin
                r_rd_vld <= rd_more;
                if (rd_more) begin
                    r_rd_idx <= r_rd_idx + 1'b1;
                end
            end
            if (i_cmd.take_miss && !tbl_full) begin
                r_used <= r_used + 1'b1;
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_addr <= i_address;
        end
        if (i_cmd.scan) begin
            r_key_q   <= key_mem[r_rd_idx[phlt_pkg::IDX_W-1:0]];
            r_cmp_idx <= r_rd_idx[phlt_pkg::IDX_W-1:0];
        end
        if (i_cmd.take_hit) begin
            r_slot <= r_cmp_idx;
            r_new  <= 1'b0;
            r_full <= 1'b0;
        end
        if (i_cmd.take_miss) begin
            r_slot <= r_used[phlt_pkg::IDX_W-1:0];
            r_new  <= 1'b1;
            r_full <= tbl_full;
            if (!tbl_full) begin
                key_mem[r_used[phlt_pkg::IDX_W-1:0]] <= r_addr;
            end
        end
        if (i_cmd.cnt_rd) begin
            r_cnt_q <= cnt_mem[r_slot];
        end
        if (i_cmd.finish) begin
            if (!r_full) begin
                cnt_mem[r_slot] <= cnt_inc;
            end
            r_out_count  <= r_full ? '0 : cnt_inc;
            r_out_status <= r_full ? phlt_pkg::STATUS_FULL :
                            (cnt_inc > r_limit) ? phlt_pkg::STATUS_OVER :
                            phlt_pkg::STATUS_WITHIN;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_hit_count = r_out_count;
    assign o_status    = r_out_status;

endmodule

// File: tb/per_address_hit_limit_table_tb.sv
`timescale 1ns / 100ps
// Testbench for the per-address hit limit table: directed, backpressure, random and table-full request streams.
module per_address_hit_limit_table_tb;

    typedef logic [phlt_pkg::ADDRESS_BITS-1:0] t_addr;
    typedef logic [phlt_pkg::COUNT_W-1:0]      t_count;
    typedef logic [phlt_pkg::STATUS_W-1:0]     t_status;

    typedef struct packed {
        t_count  hit_count;
        t_status status;
    } t_hit_result;

    logic    i_clk;
    logic    i_rst_n;
    logic    i_cfg_we;
    t_count  i_cfg_wdata;
    logic    i_in_valid;
    logic    o_in_ready;
    t_addr   i_address;
    logic    o_out_valid;
    logic    i_out_ready;
    t_count  o_hit_count;
    t_status o_status;

    // Shadow of the table; entries are claimed in order, so index < entries_claimed is valid.
    t_addr       key_tab [phlt_pkg::TABLE_ENTRIES];
    t_count      count_tab [phlt_pkg::TABLE_ENTRIES];
    int          entries_claimed = 0;
    t_count      limit_shadow = phlt_pkg::LIMIT_RESET;
    t_hit_result expected_hits [$];

    int mismatch_count = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_cycles    = 0;

    per_address_hit_limit_table dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_address   (i_address),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_hit_count (o_hit_count),
        .o_status    (o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("Mismatches found");
        $finish;
    end

    function automatic t_hit_result predict_lookup(input t_addr addr);
        t_hit_result r;
        int slot;
        slot = -1;
        for (int i = 0; i < entries_claimed; i++) begin
            if (slot < 0 && key_tab[i] == addr) slot = i;
        end
        if (slot < 0) begin
            if (entries_claimed == phlt_pkg::TABLE_ENTRIES) begin
                r.hit_count = '0;
                r.status    = phlt_pkg::STATUS_FULL;
                return r;
            end
            slot            = entries_claimed;
            key_tab[slot]   = addr;
            count_tab[slot] = '0;
            entries_claimed++;
        end
        if (count_tab[slot] != phlt_pkg::COUNT_MAX) count_tab[slot] = count_tab[slot] + 1'b1;
        r.hit_count = count_tab[slot];
        r.status    = (count_tab[slot] > limit_shadow) ? phlt_pkg::STATUS_OVER :
                                                         phlt_pkg::STATUS_WITHIN;
        return r;
    endfunction

    function automatic t_addr next_lookup_address();
        int roll;
        int hot;
        t_addr flip;
        roll = $urandom_range(99);
        hot  = (entries_claimed < 4) ? entries_claimed : 4;
        if (entries_claimed == 0) return t_addr'({$urandom, $urandom});
        if (roll < ((entries_claimed == phlt_pkg::TABLE_ENTRIES) ? 80 : 10)) begin
            if ($urandom_range(1) == 1) return key_tab[$urandom_range(hot - 1)];
            return key_tab[$urandom_range(entries_claimed - 1)];
        end
        // near miss: a stored key with one bit flipped
        if (roll < ((entries_claimed == phlt_pkg::TABLE_ENTRIES) ? 90 : 30)) begin
            flip = t_addr'(1) << $urandom_range(phlt_pkg::ADDRESS_BITS - 1);
            return key_tab[$urandom_range(entries_claimed - 1)] ^ flip;
        end
        return t_addr'({$urandom, $urandom});
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("ERROR at %0t: %s got 0x%0h want 0x%0h", $time, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin : check_results
        t_hit_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_hits.size() == 0) begin
                report_mismatch("result with no request pending", 64'(o_hit_count), '0);
            end else begin
                want = expected_hits.pop_front();
                if (o_hit_count !== want.hit_count)
                    report_mismatch("hit_count", 64'(o_hit_count), 64'(want.hit_count));
                if (o_status !== want.status)
                    report_mismatch("status", 64'(o_status), 64'(want.status));
            end
        end
    end

    initial begin
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_cycles > 0) begin
                i_out_ready <= 1'b0;
                hold_cycles--;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic send_request(input t_addr addr);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_address  <= addr;
        do @(posedge i_clk); while (!o_in_ready);
        expected_hits.push_back(predict_lookup(addr));
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (expected_hits.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_limit(input t_count value);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we     <= 1'b0;
        limit_shadow = value;
    endtask

    task automatic test_directed();
        send_request('0);
        send_request({phlt_pkg::ADDRESS_BITS{1'b1}});
        send_request('0);
        send_request({(phlt_pkg::ADDRESS_BITS / 2){2'b10}});
        send_request({(phlt_pkg::ADDRESS_BITS / 2){2'b01}});
        send_request(t_addr'(1) << (phlt_pkg::ADDRESS_BITS - 1));
        send_request(t_addr'(1));
        send_request({phlt_pkg::ADDRESS_BITS{1'b1}});
        // every hit is over a zero limit
        write_limit('0);
        send_request('0);
        send_request(t_addr'(1));
        write_limit(t_count'(1));
        send_request({(phlt_pkg::ADDRESS_BITS / 2){2'b10}});
        send_request(t_addr'(2));
        // count equal to the limit stays within, one more is over
        write_limit(t_count'(3));
        repeat (4) send_request(48'h1234_5678_9ABC);
        write_limit(phlt_pkg::COUNT_MAX);
        send_request('0);
        write_limit(t_count'($urandom));
        send_request({phlt_pkg::ADDRESS_BITS{1'b1}});
    endtask

    task automatic test_backpressure();
        write_limit(t_count'(2));
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_cycles    = 300;
        repeat (6) send_request(next_lookup_address());
        wait_drained();
    endtask

    task automatic test_random(input int s_idle, input int r_idle, input int n_items,
                               input t_count limit);
        write_limit(limit);
        send_idle_pct  = s_idle;
        recv_stall_pct = r_idle;
        repeat (n_items) begin
            if ($urandom_range(49) == 0) wait_drained();
            send_request(next_lookup_address());
        end
    endtask

    task automatic test_table_full();
        write_limit('0);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        while (entries_claimed < phlt_pkg::TABLE_ENTRIES)
            send_request(t_addr'({$urandom, $urandom}));
        send_request(t_addr'({$urandom, $urandom}));
        send_request(key_tab[phlt_pkg::TABLE_ENTRIES - 1] ^ t_addr'(1));
        send_request(key_tab[0]);
        send_request(key_tab[phlt_pkg::TABLE_ENTRIES - 1]);
        send_request(t_addr'({$urandom, $urandom}));
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= '0;
        i_in_valid  <= 1'b0;
        i_address   <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_backpressure();
        test_random(0, 0, 95, '0);
        test_random(76, 0, 95, t_count'(3));
        test_random(0, 76, 95, t_count'($urandom_range(1, 6)));
        test_random(19, 19, 95, phlt_pkg::COUNT_MAX);
        test_table_full();

        wait_drained();
        repeat (phlt_pkg::TABLE_ENTRIES + 8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
